// ----- hw/rtl/fjpd_pkg.sv -----
package fjpd_pkg;

  localparam int JointCount = 4;

  // Lane roles, index order top, left, right, neck
  typedef logic [1:0] joint_t;
  localparam joint_t J_TOP   = 2'd0;
  localparam joint_t J_LEFT  = 2'd1;
  localparam joint_t J_RIGHT = 2'd2;
  localparam joint_t J_NECK  = 2'd3;

  // Drive direction codes
  localparam logic [1:0] DIR_NEG   = 2'd0;
  localparam logic [1:0] DIR_POS   = 2'd1;
  localparam logic [1:0] DIR_BRAKE = 2'd2;

  localparam logic [9:0]  BRAKE_DUTY = 10'd512;
  localparam logic [9:0]  DUTY_FULL  = 10'd1023;
  localparam logic [13:0] ENC_MASK   = 14'h3FF0;
  localparam logic signed [15:0] LIMIT_45 = 16'sd11520;
  localparam logic signed [15:0] ANGLE_20 = 16'sd5120;

  // Sequencer steps per tick (0 .. LAST_STEP)
  localparam logic [3:0] LAST_STEP = 4'd8;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
  } gain_t;

  // Q4.12 gain sets
  localparam gain_t GAIN_TOP    = '{kp: 16'sd4506,  ki: 16'sd61,  kd: 16'sd6554};
  localparam gain_t GAIN_RISE   = '{kp: 16'sd2458,  ki: 16'sd41,  kd: 16'sd5325};
  localparam gain_t GAIN_FALL   = '{kp: 16'sd7373,  ki: 16'sd41,  kd: 16'sd6963};
  localparam gain_t GAIN_NORMAL = '{kp: 16'sd8602,  ki: 16'sd61,  kd: 16'sd6963};
  localparam gain_t GAIN_NECK   = '{kp: 16'sd11878, ki: 16'sd614, kd: 16'sd16384};

  typedef struct packed {
    logic       load;  // beat accepted: latch lane inputs
    logic       run;   // sequencer running
    logic [3:0] step;
    logic       upd;   // all four masked encoder words nonzero
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/fjpd_lane.sv -----
module fjpd_lane (
  input  logic                clk,
  input  logic                rst,
  input  fjpd_pkg::lane_ctrl_t ctrl,
  input  fjpd_pkg::joint_t    lane_id,
  input  logic [15:0]         raw,
  input  logic signed [15:0]  target,
  input  logic [13:0]         offset,
  output logic [1:0]          dir,
  output logic [9:0]          duty,
  output logic signed [15:0]  angle
);
  import fjpd_pkg::*;

  localparam logic [20:0] RECIP_26  = 21'd1290556;   // ceil(2^25/26)
  localparam logic [17:0] RECIP_100 = 18'd167773;    // ceil(2^24/100)
  localparam logic [21:0] SAT_Z     = 22'd102400;

  // held control state
  logic signed [16:0] prev_err;
  logic signed [31:0] isum;

  // per-tick working registers
  logic [13:0]        m;
  logic [13:0]        off;
  logic signed [15:0] tgt;
  logic               neg;
  logic [19:0]        p45;
  logic [16:0]        q;
  logic signed [16:0] er;
  logic signed [17:0] dr;
  logic signed [31:0] ir;
  gain_t              g;
  logic signed [43:0] acc;
  logic               s_zero;
  logic               s_neg;
  logic               big;
  logic [20:0]        y;

  logic signed [14:0] diff;
  logic [14:0]        dmag;
  logic [19:0]        xr;
  logic [40:0]        pr;
  logic signed [15:0] ang_sat;
  logic signed [16:0] e_c;
  logic signed [17:0] d_c;
  logic signed [32:0] i_wide;
  logic signed [31:0] i_sat;
  gain_t              g_sel;
  logic signed [32:0] m_kp;
  logic signed [47:0] m_ki;
  logic signed [34:0] m_kd;
  logic signed [43:0] amag;
  logic [40:0]        ym;
  logic [21:0]        z;
  logic [34:0]        qm;
  logic signed [15:0] tgt_in;

  always_comb begin
    // input clamp for top and neck
    tgt_in = target;
    if (lane_id == J_TOP || lane_id == J_NECK) begin
      if (target > LIMIT_45) tgt_in = LIMIT_45;
      else if (target < -LIMIT_45) tgt_in = -LIMIT_45;
    end

    // step 0: signed encoder delta, right and neck count the other way
    if (lane_id == J_RIGHT || lane_id == J_NECK) begin
      diff = $signed({1'b0, m}) - $signed({1'b0, off});
    end else begin
      diff = $signed({1'b0, off}) - $signed({1'b0, m});
    end
    dmag = diff[14] ? 15'(-diff) : 15'(diff);

    // step 1: round-half-away on magnitude
    xr = p45 + 20'd13;
    pr = xr * RECIP_26;

    // step 2: sign and saturate
    if (neg) begin
      ang_sat = (q > 17'd32768) ? -16'sd32768 : 16'(-$signed(q));
    end else begin
      ang_sat = (q > 17'd32767) ? 16'sd32767 : 16'(q);
    end

    // step 3: error terms and gain schedule
    e_c    = 17'(tgt) - 17'(angle);
    d_c    = 18'(e_c) - 18'(prev_err);
    i_wide = 33'(isum) + 33'(e_c);
    if (i_wide > 33'sd2147483647) i_sat = 32'sh7FFFFFFF;
    else if (i_wide < -33'sd2147483648) i_sat = 32'sh80000000;
    else i_sat = i_wide[31:0];

    case (lane_id)
      J_TOP:  g_sel = GAIN_TOP;
      J_NECK: g_sel = GAIN_NECK;
      default: begin
        if (angle > ANGLE_20 && tgt > angle) g_sel = GAIN_RISE;
        else if (angle > ANGLE_20 && tgt < angle) g_sel = GAIN_FALL;
        else g_sel = GAIN_NORMAL;
      end
    endcase

    m_kp = er * g.kp;
    m_ki = ir * g.ki;
    m_kd = dr * g.kd;

    // duty = round(|S| * 1023 / (100 * 2^20))
    amag = acc[43] ? -acc : acc;
    ym   = amag[30:0] * DUTY_FULL;
    z    = {1'b0, y} + 22'd50;
    qm   = z[16:0] * RECIP_100;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle    <= '0;
      prev_err <= '0;
      isum     <= '0;
    end else if (ctrl.run) begin
      if (ctrl.step == 4'd2 && ctrl.upd) begin
        angle <= ang_sat;
      end
      if (ctrl.step == 4'd3) begin
        prev_err <= e_c;
        isum     <= i_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      m   <= raw[13:0] & ENC_MASK;
      off <= offset;
      tgt <= tgt_in;
    end else if (ctrl.run) begin
      case (ctrl.step)
        4'd0: begin
          neg <= diff[14];
          p45 <= dmag[13:0] * 6'd45;
        end
        4'd1: begin
          case (lane_id)
            J_TOP:   q <= {1'b0, pr[40:25]};
            J_NECK:  q <= 17'((p45 + 20'd4) >> 3);
            default: q <= 17'((p45 + 20'd8) >> 4);
          endcase
        end
        4'd3: begin
          er <= e_c;
          dr <= d_c;
          ir <= i_sat;
          g  <= g_sel;
        end
        4'd4: acc <= 44'(m_kp);
        4'd5: acc <= acc + 44'(m_ki);
        4'd6: acc <= acc + 44'(m_kd);
        4'd7: begin
          s_zero <= (acc == '0);
          s_neg  <= acc[43];
          big    <= |amag[43:31];
          y      <= ym[40:20];
        end
        4'd8: begin
          if (s_zero) begin
            dir  <= DIR_BRAKE;
            duty <= BRAKE_DUTY;
          end else begin
            dir  <= s_neg ? DIR_NEG : DIR_POS;
            duty <= (big || z >= SAT_Z) ? DUTY_FULL : qm[33:24];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/four_joint_pid_motor_drive.sv -----
// Four-joint PID motor drive. One input beat is one control tick: four raw
// encoder words and four Q8.8 target angles. Each word is masked to bits
// 13:4; only when all four masked words are nonzero are the joint angles
// refreshed from the words and the offset registers, otherwise the held
// angles carry over. Top and neck targets clamp to +-45 degrees. Each joint
// runs a PID with held error and saturating 32-bit integral; left and right
// schedule gains on angle above 20 degrees and error sign. Per joint the
// result gives a direction code (0 neg, 1 pos, 2 brake at duty 512), a
// 10-bit duty and the updated angle. Four lanes run in parallel, each with
// its own datapath stepped by a shared 9-step sequencer. The result
// waits in the done state until it moves into the output register; a
// new beat is taken once the previous tick has moved into the output
// register. Offsets are written on the cfg channel (always ready); the
// user must write them only while idle, which the block does not enforce.
module four_joint_pid_motor_drive (
  input  logic         clk,
  input  logic         rst,
  // top_raw, left_raw, right_raw, neck_raw, top_target, left_target,
  // right_target, neck_target (16 bits each, low to high)
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  // top_dir, top_duty, left_dir, left_duty, right_dir, right_duty,
  // neck_dir, neck_duty, top_angle, left_angle, right_angle, neck_angle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [13:0]  cfg_data
);
  import fjpd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [3:0]  step;
  logic        upd;
  logic [13:0] offsets [JointCount];
  lane_ctrl_t  ctrl;
  logic        accept;
  logic        all_nz;
  logic        out_load;

  logic [1:0]         l_dir   [JointCount];
  logic [9:0]         l_duty  [JointCount];
  logic signed [15:0] l_angle [JointCount];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // angle refresh only when every masked word is nonzero
  assign all_nz = (|s_axis_tdata[13:4])  && (|s_axis_tdata[29:20]) &&
                  (|s_axis_tdata[45:36]) && (|s_axis_tdata[61:52]);

  assign ctrl = '{load: accept, run: (state == ST_RUN), step: step, upd: upd};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JointCount; j++) offsets[j] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offsets[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      upd           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= '0;
            upd   <= all_nz;
          end
        end
        ST_RUN: begin
          step <= step + 4'd1;
          if (step == LAST_STEP) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar j = 0; j < JointCount; j++) begin : g_lane
    fjpd_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .lane_id (joint_t'(j)),
      .raw     (s_axis_tdata[16*j +: 16]),
      .target  ($signed(s_axis_tdata[64 + 16*j +: 16])),
      .offset  (offsets[j]),
      .dir     (l_dir[j]),
      .duty    (l_duty[j]),
      .angle   (l_angle[j])
    );
  end

  // merge lanes into the result beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int j = 0; j < JointCount; j++) begin
        m_axis_tdata[12*j +: 12]      <= {l_duty[j], l_dir[j]};
        m_axis_tdata[48 + 16*j +: 16] <= l_angle[j];
      end
    end
  end

endmodule

// ----- hw/rtl/fjpd_checker.sv -----
module fjpd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);
  import fjpd_pkg::*;

  // held result beat stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one tick at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken during a tick");

  // top joint brake always comes with half duty
  a_brake: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == DIR_BRAKE |-> m_axis_tdata[11:2] == BRAKE_DUTY)
    else $error("top brake without half duty");

  // direction code never unused
  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[13:12] != 2'd3 && m_axis_tdata[25:24] != 2'd3 &&
                      m_axis_tdata[37:36] != 2'd3 && m_axis_tdata[1:0] != 2'd3)
    else $error("bad direction code");

  // nothing comes out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind four_joint_pid_motor_drive fjpd_checker u_fjpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/four_joint_pid_motor_drive_tb.sv -----
`timescale 1ns / 100ps

module four_joint_pid_motor_drive_tb;
  import fjpd_pkg::*;

  // One control tick as the predictor sees it: raw words, then targets.
  typedef struct {
    logic [15:0] raw [4];
    logic signed [15:0] tgt [4];
  } tick_t;

  // One expected drive result: dir, duty and angle per joint.
  typedef struct {
    logic [1:0] dir [4];
    logic [9:0] duty [4];
    logic signed [15:0] ang [4];
  } drive_t;

  int unsigned fail_count = 0;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Scoreboard: holds a copy of the joint state and the queue of pending drives.
  class drive_scoreboard;
    logic signed [15:0] angle_q [4];
    longint prev_err [4];
    longint integ [4];
    logic [13:0] offset [4];
    drive_t pending [$];

    function new();
      for (int j = 0; j < 4; j++) begin
        angle_q[j] = 0;
        prev_err[j] = 0;
        integ[j] = 0;
        offset[j] = 0;
      end
    endfunction

    static function longint round_quot(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    static function logic signed [15:0] sat_angle(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    static function longint clamp_45(longint v);
      if (v > LIMIT_45) return LIMIT_45;
      if (v < -LIMIT_45) return -LIMIT_45;
      return v;
    endfunction

    function void pid_lane(int j, longint target, gain_t g, ref drive_t r);
      longint e, d, i, s, mag, q;
      e = target - longint'(angle_q[j]);
      d = e - prev_err[j];
      i = integ[j] + e;
      if (i > 64'sd2147483647) i = 64'sd2147483647;
      if (i < -64'sd2147483648) i = -64'sd2147483648;
      integ[j] = i;
      prev_err[j] = e;
      s = longint'(g.kp) * e + longint'(g.ki) * i + longint'(g.kd) * d;
      if (s == 0) begin
        r.dir[j] = DIR_BRAKE;
        r.duty[j] = BRAKE_DUTY;
        return;
      end
      r.dir[j] = (s < 0) ? DIR_NEG : DIR_POS;
      mag = (s < 0) ? -s : s;
      q = (mag * 1023 + 52428800) / 104857600;
      r.duty[j] = (q > 1023) ? DUTY_FULL : q[9:0];
    endfunction

    function gain_t side_gains(int j, longint target);
      longint a;
      a = angle_q[j];
      if (a > ANGLE_20 && target > a) return GAIN_RISE;
      if (a > ANGLE_20 && target < a) return GAIN_FALL;
      return GAIN_NORMAL;
    endfunction

    // Note an accepted tick and queue the drive it must produce.
    function void note_tick(tick_t t);
      longint m [4];
      longint tt, tn;
      drive_t r;
      for (int j = 0; j < 4; j++) m[j] = t.raw[j] & 16'h3FF0;
      if (m[0] != 0 && m[1] != 0 && m[2] != 0 && m[3] != 0) begin
        angle_q[0] = sat_angle(round_quot((longint'(offset[0]) - m[0]) * 45, 26));
        angle_q[1] = sat_angle(round_quot((longint'(offset[1]) - m[1]) * 45, 16));
        angle_q[2] = sat_angle(round_quot((m[2] - longint'(offset[2])) * 45, 16));
        angle_q[3] = sat_angle(round_quot((m[3] - longint'(offset[3])) * 45, 8));
      end
      tt = clamp_45(t.tgt[0]);
      tn = clamp_45(t.tgt[3]);
      pid_lane(0, tt, GAIN_TOP, r);
      pid_lane(1, t.tgt[1], side_gains(1, t.tgt[1]), r);
      pid_lane(2, t.tgt[2], side_gains(2, t.tgt[2]), r);
      pid_lane(3, tn, GAIN_NECK, r);
      for (int j = 0; j < 4; j++) r.ang[j] = angle_q[j];
      pending.push_back(r);
    endfunction

    // Compare one output beat against the oldest pending drive.
    task check_drive(logic [111:0] data);
      drive_t x;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output beat %h", data));
        return;
      end
      x = pending.pop_front();
      for (int j = 0; j < 4; j++) begin
        if (data[12*j +: 2] !== x.dir[j])
          report($sformatf("joint %0d dir got %0d exp %0d", j, data[12*j +: 2], x.dir[j]));
        if (data[12*j+2 +: 10] !== x.duty[j])
          report($sformatf("joint %0d duty got %0d exp %0d", j, data[12*j+2 +: 10],
                           x.duty[j]));
        if (data[48+16*j +: 16] !== x.ang[j])
          report($sformatf("joint %0d angle got %0d exp %0d", j,
                           $signed(data[48+16*j +: 16]), x.ang[j]));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  drive_scoreboard sb = new();

  // Receiver hold-off: while nonzero, tready stays low.
  int unsigned hold_cycles = 0;
  bit quiet_sink = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  four_joint_pid_motor_drive u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result side: accepted beats checked at the edge, tready re-driven after.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
    if (rst) m_axis_tready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_axis_tready <= 0;
    end else if (quiet_sink) m_axis_tready <= 1;
    else m_axis_tready <= (($urandom_range(0, 15) >> (($time / 4000) % 3)) != 0);
  end

  // Leaves cfg_valid up so several writes can run back to back.
  task automatic write_offset(input int idx, input logic [13:0] val);
    cfg_valid <= 1;
    cfg_index <= idx[1:0];
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.offset[idx] = val;
  endtask

  // Present one tick and hold it until the block takes the beat.
  task automatic send_tick(input tick_t t);
    logic [127:0] beat;
    for (int j = 0; j < 4; j++) begin
      beat[16*j +: 16] = t.raw[j];
      beat[64+16*j +: 16] = t.tgt[j];
    end
    s_axis_tdata <= beat;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(t);
  endtask

  task automatic idle_cycles(input int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Random tick: mostly valid encoder words near the offsets, targets
  // mostly within a plausible band, with some full-range noise.
  function automatic tick_t rand_tick();
    tick_t t;
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 9))
        0: t.raw[j] = 16'($urandom_range(0, 15)) | (16'($urandom_range(0, 3)) << 14);
        1, 2: t.raw[j] = 16'($urandom);
        default: t.raw[j] = 16'((sb.offset[j] + $urandom_range(0, 600) - 300) & 16'h3FFF);
      endcase
      case ($urandom_range(0, 5))
        0: t.tgt[j] = 16'($urandom);
        1: t.tgt[j] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: t.tgt[j] = $signed(16'($urandom_range(0, 30000))) - 16'sd15000;
      endcase
    end
    return t;
  endfunction

  task automatic random_phase(input int n);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 25));
      end
      send_tick(rand_tick());
      burst--;
    end
  endtask

  initial begin
    tick_t t;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero words (angles held), field extremes, clamps, brake.
    for (int k = 0; k < 20; k++) begin
      for (int j = 0; j < 4; j++) begin
        case (k % 5)
          0: t.raw[j] = 16'h0000;
          1: t.raw[j] = 16'hFFFF;
          2: t.raw[j] = 16'hC00F;
          3: t.raw[j] = 16'h0010;
          default: t.raw[j] = 16'h3FF0;
        endcase
        case (k % 4)
          0: t.tgt[j] = 16'sh7FFF;
          1: t.tgt[j] = 16'sh8000;
          2: t.tgt[j] = 16'sd0;
          default: t.tgt[j] = (k < 10) ? 16'sd6000 : -16'sd11600;
        endcase
      end
      if (k == 19) t.raw[2] = 16'h0000;
      send_tick(t);
    end
    drain();

    // Offsets at their extremes, then several random settings.
    for (int ph = 0; ph < 5; ph++) begin
      for (int j = 0; j < 4; j++)
        write_offset(j, ph == 0 ? 14'h3FFF : ph == 1 ? 14'h0000 : 14'($urandom));
      cfg_valid <= 0;
      random_phase(ph == 2 ? 100 : 120);
      if (ph == 1) begin
        // Long receiver stall while the sender keeps offering beats.
        hold_cycles = 300;
        random_phase(10);
      end
      drain();
    end

    // A stretch with no idling on either side.
    quiet_sink = 1;
    for (int k = 0; k < 30; k++) send_tick(rand_tick());
    drain();

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- four_joint_pid_motor_drive.f -----
hw/rtl/fjpd_pkg.sv
hw/rtl/fjpd_lane.sv
hw/rtl/four_joint_pid_motor_drive.sv
hw/rtl/fjpd_checker.sv
tb/sv/four_joint_pid_motor_drive_tb.sv
